/* rtl/sdz_pkg.sv */
// shared constants and types for the stick dead zone and octagonal gate block
`timescale 1ns / 1ps
package sdz_pkg;

  localparam int AXIS_W   = 8;
  localparam int DZ_W     = 7;
  localparam int SENS_W   = 16;
  localparam int OUT_W    = 16;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;
  localparam int MAG_W    = 8;
  localparam int R2_W     = 16;
  localparam int ROOT_W   = 24;
  localparam int NUM1_W   = 45;
  localparam int DEN1_W   = 29;
  localparam int NUM2_W   = 31;
  localparam int DEN2_W   = 14;
  localparam int QUO_W    = 17;
  localparam int MX1_W    = 25;
  localparam int MX2_W    = 26;
  localparam int MX3_W    = 18;

  localparam int FULL_SCALE  = 85;
  localparam int EDGE_NUM    = 16;
  localparam int EDGE_DEN    = 69;
  localparam int MAX_DZ      = 84;
  localparam int SENS_RESET  = 4096;

  localparam logic [CFG_AW-1:0] REG_LEFT_DZ  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_RIGHT_DZ = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CAM_SENS = 2'd2;

  typedef struct packed {
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic             sx;
    logic             sy;
    logic             right;
    logic             zero;
  } sdz_side_t;

  typedef struct packed {
    sdz_side_t        s;
    logic [DZ_W-1:0]  t;
  } sdz_rside_t;

endpackage

/* rtl/sdz_sqrt.sv */
// pipelined integer square root of r2 * 2^32, one result bit per stage
`timescale 1ns / 1ps
module sdz_sqrt #(
  parameter int SW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [sdz_pkg::R2_W-1:0]  r2,
  input  logic [SW-1:0]             side_in,
  output logic                      out_valid,
  output logic [sdz_pkg::ROOT_W-1:0] root,
  output logic [SW-1:0]             side_out
);
  import sdz_pkg::*;

  localparam int N  = ROOT_W;
  localparam int RW = ROOT_W + 2;

  logic [R2_W-1:0]   r2_s  [N];
  logic [RW-1:0]     rem_s [N];
  logic [ROOT_W-1:0] q_s   [N+1];
  logic              v_s   [N+1];
  logic [SW-1:0]     sd_s  [N+1];

  assign r2_s[0]  = r2;
  assign rem_s[0] = '0;
  assign q_s[0]   = '0;
  assign v_s[0]   = in_valid;
  assign sd_s[0]  = side_in;

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int I = N - 1 - j;
    logic [1:0]    pair;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          ge;

    if (I >= 16) begin : g_pair
      assign pair = r2_s[j][2*(I-16)+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign cur   = {rem_s[j], pair};
    assign trial = {2'b00, q_s[j], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else if (en) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_s[j+1]  <= {q_s[j][ROOT_W-2:0], ge};
        sd_s[j+1] <= sd_s[j];
      end
    end

    if (j < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[j+1] <= ge ? RW'(cur - trial) : RW'(cur);
          r2_s[j+1]  <= r2_s[j];
        end
      end
    end
  end

  assign out_valid = v_s[N];
  assign root      = q_s[N];
  assign side_out  = sd_s[N];

endmodule

/* rtl/sdz_div.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module sdz_div #(
  parameter int NW = 45,
  parameter int DW = 29,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);
  import sdz_pkg::*;

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_s [QW];
  logic [DW-1:0] den_s [QW];
  logic [QW-1:0] q_s   [QW+1];
  logic          v_s   [QW+1];
  logic [SW-1:0] sd_s  [QW+1];

  assign rem_s[0] = W'(num);
  assign den_s[0] = den;
  assign q_s[0]   = '0;
  assign v_s[0]   = in_valid;
  assign sd_s[0]  = side_in;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int I = QW - 1 - j;
    logic [W-1:0]  shd;
    logic          ge;
    logic [QW-1:0] q_nxt;

    assign shd = W'(den_s[j]) << I;
    assign ge  = rem_s[j] >= shd;

    always_comb begin
      q_nxt    = q_s[j];
      q_nxt[I] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else if (en) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_s[j+1]  <= q_nxt;
        sd_s[j+1] <= sd_s[j];
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[j+1] <= ge ? rem_s[j] - shd : rem_s[j];
          den_s[j+1] <= den_s[j];
        end
      end
    end
  end

  assign out_valid = v_s[QW];
  assign quo       = q_s[QW];
  assign side_out  = sd_s[QW];

endmodule

/* rtl/stick_deadzone_octagon_gate.sv */
// top level: radial dead zone, rescale, octagonal gate and camera gain (right stick only)
`timescale 1ns / 1ps
// usage:
//   input channel in_valid/in_ready carries one stick sample (in_x, in_y,
//   is_right); output channel out_valid/out_ready carries one conditioned
//   result (out_x, out_y, out_is_right) per sample, in order.
//   an accepted transaction passes through 1 input stage, 24 square root
//   stages, 1 setup stage, 17 divider stages (rescale and gate divides
//   run side by side), 3 multiply stages and the output register.
//   throughput is one transaction per cycle while out_ready does not
//   hold the pipeline, set by the one-bit-per-stage root and divider
//   pipelines.
//   cfg_wr_en/cfg_addr/cfg_wdata write the dead zones (index 0, 1) and the
//   camera gain (index 2); write only while no transaction is in flight.
//   reset clears all valid bits and loads dead zones 0 and gain 16.0.
//   when out_ready is low with a result waiting the whole pipeline holds
//   and in_ready drops in the same cycle; nothing is dropped or repeated.
module stick_deadzone_octagon_gate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [sdz_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [sdz_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sdz_pkg::AXIS_W-1:0] in_x,
  input  logic signed [sdz_pkg::AXIS_W-1:0] in_y,
  input  logic                              is_right,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sdz_pkg::OUT_W-1:0]  out_x,
  output logic signed [sdz_pkg::OUT_W-1:0]  out_y,
  output logic                              out_is_right
);
  import sdz_pkg::*;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // configuration registers
  logic [DZ_W-1:0]   left_dz;
  logic [DZ_W-1:0]   right_dz;
  logic [SENS_W-1:0] cam_sens;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= '0;
      right_dz <= '0;
      cam_sens <= SENS_W'(SENS_RESET);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_LEFT_DZ:  left_dz  <= cfg_wdata[DZ_W-1:0];
        REG_RIGHT_DZ: right_dz <= cfg_wdata[DZ_W-1:0];
        REG_CAM_SENS: cam_sens <= cfg_wdata[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic [MAG_W-1:0] a_in, b_in;
  logic [DZ_W-1:0]  t_raw, t_sat;
  assign a_in  = in_x[AXIS_W-1] ? MAG_W'(-in_x) : MAG_W'(in_x);
  assign b_in  = in_y[AXIS_W-1] ? MAG_W'(-in_y) : MAG_W'(in_y);
  assign t_raw = is_right ? right_dz : left_dz;
  assign t_sat = (t_raw > DZ_W'(MAX_DZ)) ? DZ_W'(MAX_DZ) : t_raw;

  logic            v0;
  logic [R2_W-1:0] r2_0;
  sdz_rside_t      rs0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_0       <= R2_W'(a_in * a_in) + R2_W'(b_in * b_in);
      rs0.s.a    <= a_in;
      rs0.s.b    <= b_in;
      rs0.s.sx   <= in_x[AXIS_W-1];
      rs0.s.sy   <= in_y[AXIS_W-1];
      rs0.s.right <= is_right;
      rs0.s.zero <= (a_in == '0) && (b_in == '0);
      rs0.t      <= t_sat;
    end
  end

  // square root
  logic              v1;
  logic [ROOT_W-1:0] len1;
  sdz_rside_t        rs1;

  sdz_sqrt #(.SW($bits(sdz_rside_t))) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v0), .r2(r2_0), .side_in(rs0),
    .out_valid(v1), .root(len1), .side_out(rs1)
  );

  // divider setup
  logic [ROOT_W-1:0] thr;
  logic [ROOT_W-1:0] fs_len;
  logic [DEN2_W-1:0] d1, d2;
  assign thr    = ROOT_W'({rs1.t, 16'h0000});
  assign fs_len = ROOT_W'(FULL_SCALE) << 16;
  assign d1     = DEN2_W'(EDGE_DEN) * DEN2_W'(rs1.s.b) + DEN2_W'(EDGE_NUM) * DEN2_W'(rs1.s.a);
  assign d2     = DEN2_W'(EDGE_DEN) * DEN2_W'(rs1.s.a) + DEN2_W'(EDGE_NUM) * DEN2_W'(rs1.s.b);

  logic              v2;
  logic [NUM1_W-1:0] num1;
  logic [DEN1_W-1:0] den1;
  logic [NUM2_W-1:0] num2;
  logic [DEN2_W-1:0] den2;
  sdz_side_t         s2;
  logic              g2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2   <= rs1.s;
      g2   <= (rs1.s.a != '0) && (rs1.s.b != '0);
      num2 <= NUM2_W'(len1) * NUM2_W'(EDGE_DEN);
      den2 <= rs1.s.zero ? DEN2_W'(1) : ((d1 > d2) ? d1 : d2);
      priority if (rs1.s.zero || len1 < thr) begin
        num1 <= '0;
        den1 <= DEN1_W'(1);
      end else if (len1 > fs_len) begin
        num1 <= NUM1_W'(FULL_SCALE) << 32;
        den1 <= DEN1_W'(len1);
      end else begin
        num1 <= (NUM1_W'(len1 - thr) * NUM1_W'(FULL_SCALE)) << 16;
        den1 <= DEN1_W'(len1) * DEN1_W'(DZ_W'(FULL_SCALE) - rs1.t);
      end
    end
  end

  // rescale and gate divides
  logic             v3, v3b;
  logic [QUO_W-1:0] k3, sc3;
  sdz_side_t        s3;
  logic             g3;

  sdz_div #(.NW(NUM1_W), .DW(DEN1_W), .QW(QUO_W), .SW($bits(sdz_side_t))) u_div_k (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2), .num(num1), .den(den1), .side_in(s2),
    .out_valid(v3), .quo(k3), .side_out(s3)
  );

  sdz_div #(.NW(NUM2_W), .DW(DEN2_W), .QW(QUO_W), .SW(1)) u_div_s (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2), .num(num2), .den(den2), .side_in(g2),
    .out_valid(v3b), .quo(sc3), .side_out(g3)
  );

  // multiply stages
  logic             v4, v5, v6;
  logic [MX1_W-1:0] mx4, my4;
  logic [QUO_W-1:0] sc4;
  logic             g4;
  sdz_side_t        s4, s5, s6;
  logic [MX2_W-1:0] mx5, my5;
  logic [MX3_W-1:0] mx6, my6;
  logic [MX1_W+QUO_W-1:0]  px5, py5;
  logic [MX2_W+SENS_W-1:0] px6, py6;

  assign px5 = (MX1_W+QUO_W)'(mx4) * (MX1_W+QUO_W)'(sc4);
  assign py5 = (MX1_W+QUO_W)'(my4) * (MX1_W+QUO_W)'(sc4);
  assign px6 = (MX2_W+SENS_W)'(mx5) * (MX2_W+SENS_W)'(cam_sens);
  assign py6 = (MX2_W+SENS_W)'(my5) * (MX2_W+SENS_W)'(cam_sens);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= v3 && v3b;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx4 <= MX1_W'(s3.a) * MX1_W'(k3);
      my4 <= MX1_W'(s3.b) * MX1_W'(k3);
      sc4 <= sc3;
      g4  <= g3;
      s4  <= s3;
      if (g4 && mx4 != '0 && my4 != '0) begin
        mx5 <= MX2_W'(px5 >> 16);
        my5 <= MX2_W'(py5 >> 16);
      end else begin
        mx5 <= MX2_W'(mx4);
        my5 <= MX2_W'(my4);
      end
      s5 <= s4;
      priority if (s5.zero) begin
        mx6 <= '0;
        my6 <= '0;
      end else if (s5.right) begin
        mx6 <= MX3_W'(px6 >> 24);
        my6 <= MX3_W'(py6 >> 24);
      end else begin
        mx6 <= MX3_W'(mx5 >> 16);
        my6 <= MX3_W'(my5 >> 16);
      end
      s6 <= s5;
    end
  end

  // saturation and sign, output register
  function automatic logic [OUT_W-1:0] to_out(input logic [MX3_W-1:0] mag, input logic neg);
    logic [MX3_W-1:0] m;
    begin
      if (neg) begin
        m = (mag > MX3_W'(32768)) ? MX3_W'(32768) : mag;
        to_out = OUT_W'(-m);
      end else begin
        m = (mag > MX3_W'(32767)) ? MX3_W'(32767) : mag;
        to_out = OUT_W'(m);
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x        <= to_out(mx6, s6.sx);
      out_y        <= to_out(my6, s6.sy);
      out_is_right <= s6.right;
    end
  end

endmodule

/* rtl/sdz_checker.sv */
// port-level checks for the stick dead zone block and its bind
`timescale 1ns / 1ps
module sdz_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [sdz_pkg::OUT_W-1:0]  out_x,
  input logic signed [sdz_pkg::OUT_W-1:0]  out_y,
  input logic                              out_is_right
);
  import sdz_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_is_right))
    else $error("stalled result changed");

  // pipeline takes input whenever the output side can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output side");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind stick_deadzone_octagon_gate sdz_checker u_sdz_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_x(out_x), .out_y(out_y), .out_is_right(out_is_right)
);
